/* hdl/fpcs_pkg.sv */
// fpcs_pkg: constants, word classes and cost function for the fpc page size core
package fpcs_pkg;

  localparam int unsigned NUM_CLASSES = 6;
  localparam int unsigned COST_W = 6;

  // configuration register indexes
  localparam logic [1:0] CFG_LINE_WORDS = 2'd0;
  localparam logic [1:0] CFG_PAGE_LINES = 2'd1;
  localparam logic [1:0] CFG_INDEX_BITS = 2'd2;

  localparam logic [6:0] RST_LINE_WORDS = 7'd16;
  localparam logic [8:0] RST_PAGE_LINES = 9'd64;
  localparam logic [3:0] RST_INDEX_BITS = 4'd4;

  localparam logic [31:0] CLASS_MASK [NUM_CLASSES] = '{
    32'h0000_0000, 32'h0000_0007, 32'h0000_007f,
    32'h0000_7fff, 32'h7fff_0000, 32'h007f_007f
  };
  localparam logic [31:0] CLASS_NEG [NUM_CLASSES] = '{
    32'hffff_ffff, 32'hffff_fff8, 32'hffff_ff80,
    32'hffff_8000, 32'hffff_ffff, 32'hff80_ff80
  };
  localparam logic [COST_W-1:0] CLASS_COST [NUM_CLASSES] = '{
    6'd6, 6'd7, 6'd11, 6'd19, 6'd19, 6'd19
  };
  localparam logic [COST_W-1:0] COST_REP_BYTE = 6'd11;
  localparam logic [COST_W-1:0] COST_RAW      = 6'd32;

  // first matching class wins, so walk from the last class down
  function automatic logic [COST_W-1:0] word_cost(input logic [31:0] w);
    logic [COST_W-1:0] c;
    c = COST_RAW;
    if (w == {4{w[7:0]}}) begin
      c = COST_REP_BYTE;
    end
    for (int j = NUM_CLASSES - 1; j >= 0; j--) begin
      if (((w | CLASS_MASK[j]) == CLASS_MASK[j]) || (w[31] && (w >= CLASS_NEG[j]))) begin
        c = CLASS_COST[j];
      end
    end
    return c;
  endfunction

endpackage

/* hdl/fpc_page_compressed_size_core.sv */
// fpc_page_compressed_size_core: frequent pattern compressed size of a page of 32-bit words
//
//  channel  | direction | contents
//  s_axis   | in        | tdata: data_word[31:0]
//  m_axis   | out       | tdata: page_bytes[16:0], lines_compressed[25:17], zeros; tuser: overflowed
//  cfg      | in        | cfg_index_i: register index, cfg_data_i: value (low bits used)
//
//  one word per cycle unless a page-closing word stalls; a word is held in the input
//  register, and its page result is registered in the result register for m_axis
//  rst_ni clears counters, pipeline valids and loads the default configuration
//  a word that closes a page waits in the input register while the result register
//  is full and not taken; other words never stall
//  a configuration write clears the page in progress
module fpc_page_compressed_size_core
  import fpcs_pkg::*;
#(
  parameter int unsigned MAX_LINE_WORDS = 64,
  parameter int unsigned MAX_PAGE_LINES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // data_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // page_bytes, lines_compressed, zero fill
  output logic        m_axis_tuser,   // overflowed
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  localparam int unsigned LWW  = $clog2(MAX_LINE_WORDS + 1);
  localparam int unsigned PLW  = $clog2(MAX_PAGE_LINES + 1);
  localparam int unsigned LBW  = $clog2(MAX_LINE_WORDS * 32 + 1);
  localparam int unsigned LYW  = $clog2(MAX_LINE_WORDS * 4 + 1);
  localparam int unsigned PTW  = $clog2(MAX_PAGE_LINES * MAX_LINE_WORDS * 4 + 1);
  localparam int unsigned SUMW = PTW + 1;
  localparam int unsigned IPW  = PLW + 4;

  // configuration registers
  logic [6:0] cfg_lw_q;
  logic [8:0] cfg_pl_q;
  logic [3:0] cfg_ib_q;
  logic       cfg_wr;

  // derived configuration
  logic [LWW-1:0]  lw_d, lw_q;
  logic [PLW-1:0]  pl_d, pl_q;
  logic [LYW-1:0]  line_size_d, line_size_q;
  logic [PTW-1:0]  page_cap_d, page_cap_q;
  logic [SUMW-1:0] index_bytes_d, index_bytes_q;
  logic [IPW-1:0]  index_prod;

  // input register
  logic        s1_valid_q;
  logic [31:0] s1_word_q;
  logic        s1_go;

  // page state
  logic [LWW-1:0] wil_d, wil_q;
  logic [PLW-1:0] lip_d, lip_q;
  logic [LBW-1:0] lbits_d, lbits_q;
  logic [PTW-1:0] page_d, page_q;
  logic [PLW-1:0] small_d, small_q;

  logic [COST_W-1:0] cost;
  logic [LBW:0]      lbits_sum;
  logic [LBW:0]      lbits_rnd;
  logic [LYW-1:0]    line_bytes;
  logic [SUMW-1:0]   page_sum;
  logic [SUMW-1:0]   total;
  logic [PLW-1:0]    small_sum;
  logic              line_end;
  logic              page_end;
  logic              over;

  // result register
  logic        out_valid_d, out_valid_q;
  logic [16:0] out_bytes_d, out_bytes_q;
  logic [8:0]  out_lines_d, out_lines_q;
  logic        out_over_d, out_over_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr = cfg_valid_i && ((cfg_index_i == CFG_LINE_WORDS) ||
                                  (cfg_index_i == CFG_PAGE_LINES) ||
                                  (cfg_index_i == CFG_INDEX_BITS));

  always_comb begin
    if (cfg_lw_q == 7'd0) begin
      lw_d = LWW'(1);
    end else if (int'(cfg_lw_q) > int'(MAX_LINE_WORDS)) begin
      lw_d = LWW'(MAX_LINE_WORDS);
    end else begin
      lw_d = LWW'(cfg_lw_q);
    end
    if (cfg_pl_q == 9'd0) begin
      pl_d = PLW'(1);
    end else if (int'(cfg_pl_q) > int'(MAX_PAGE_LINES)) begin
      pl_d = PLW'(MAX_PAGE_LINES);
    end else begin
      pl_d = PLW'(cfg_pl_q);
    end
    line_size_d   = LYW'(lw_d) << 2;
    page_cap_d    = (PTW'(pl_d) * PTW'(lw_d)) << 2;
    index_prod    = IPW'(cfg_ib_q) * IPW'(pl_d);
    index_bytes_d = SUMW'(index_prod >> 3);
  end

  always_ff @(posedge clk_i) begin
    lw_q          <= lw_d;
    pl_q          <= pl_d;
    line_size_q   <= line_size_d;
    page_cap_q    <= page_cap_d;
    index_bytes_q <= index_bytes_d;
  end

  // line and page boundaries depend on counters and the registered configuration only
  assign line_end = ((LWW + 1)'(wil_q) + 1'b1) >= (LWW + 1)'(lw_q);
  assign page_end = line_end && (((PLW + 1)'(lip_q) + 1'b1) >= (PLW + 1)'(pl_q));

  assign s1_go = s1_valid_q && (!page_end || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_go;

  always_comb begin
    cost       = word_cost(s1_word_q);
    lbits_sum  = (LBW + 1)'(lbits_q) + (LBW + 1)'(cost);
    lbits_rnd  = lbits_sum + (LBW + 1)'(7);
    line_bytes = LYW'(lbits_rnd >> 3);
    page_sum   = SUMW'(page_q) + SUMW'(line_bytes);
    small_sum  = small_q + PLW'(line_bytes < line_size_q);
    total      = page_sum + index_bytes_q;
    over       = total > SUMW'(page_cap_q);

    wil_d   = wil_q;
    lip_d   = lip_q;
    lbits_d = lbits_q;
    page_d  = page_q;
    small_d = small_q;

    out_valid_d = out_valid_q && !m_axis_tready;
    out_bytes_d = out_bytes_q;
    out_lines_d = out_lines_q;
    out_over_d  = out_over_q;

    if (cfg_wr) begin
      wil_d   = '0;
      lip_d   = '0;
      lbits_d = '0;
      page_d  = '0;
      small_d = '0;
    end else if (s1_go) begin
      if (!line_end) begin
        wil_d   = wil_q + 1'b1;
        lbits_d = LBW'(lbits_sum);
      end else if (!page_end) begin
        wil_d   = '0;
        lbits_d = '0;
        lip_d   = lip_q + 1'b1;
        page_d  = PTW'(page_sum);
        small_d = small_sum;
      end else begin
        wil_d       = '0;
        lbits_d     = '0;
        lip_d       = '0;
        page_d      = '0;
        small_d     = '0;
        out_valid_d = 1'b1;
        out_bytes_d = over ? 17'(page_cap_q) : 17'(total);
        out_lines_d = 9'(small_sum);
        out_over_d  = over;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_lw_q    <= RST_LINE_WORDS;
      cfg_pl_q    <= RST_PAGE_LINES;
      cfg_ib_q    <= RST_INDEX_BITS;
      s1_valid_q  <= 1'b0;
      wil_q       <= '0;
      lip_q       <= '0;
      lbits_q     <= '0;
      page_q      <= '0;
      small_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_LINE_WORDS: cfg_lw_q <= cfg_data_i[6:0];
          CFG_PAGE_LINES: cfg_pl_q <= cfg_data_i;
          CFG_INDEX_BITS: cfg_ib_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      wil_q       <= wil_d;
      lip_q       <= lip_d;
      lbits_q     <= lbits_d;
      page_q      <= page_d;
      small_q     <= small_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_word_q <= s_axis_tdata;
    end
    out_bytes_q <= out_bytes_d;
    out_lines_q <= out_lines_d;
    out_over_q  <= out_over_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_lines_q, out_bytes_q};
  assign m_axis_tuser  = out_over_q;

endmodule
